### rtl/core/f4tp_pkg.sv
// Package: format codes, constants and float conversion helpers for the texel packer.
`default_nettype none
package f4tp_pkg;
    localparam int unsigned FmtW = 4;
    localparam int unsigned ChW  = 32;
    localparam int unsigned UsedW = 3;

    localparam logic [FmtW-1:0] FMT_R8_UNORM   = 4'd0;
    localparam logic [FmtW-1:0] FMT_R8_UINT    = 4'd1;
    localparam logic [FmtW-1:0] FMT_RG8_UNORM  = 4'd2;
    localparam logic [FmtW-1:0] FMT_RGB8_UNORM = 4'd3;
    localparam logic [FmtW-1:0] FMT_RGBA8_UNORM = 4'd4;
    localparam logic [FmtW-1:0] FMT_R16_UNORM  = 4'd5;
    localparam logic [FmtW-1:0] FMT_R16_UINT   = 4'd6;
    localparam logic [FmtW-1:0] FMT_F32_X1     = 4'd7;
    localparam logic [FmtW-1:0] FMT_F32_X2     = 4'd8;
    localparam logic [FmtW-1:0] FMT_F32_X3     = 4'd9;
    localparam logic [FmtW-1:0] FMT_F32_X4     = 4'd10;
    localparam logic [FmtW-1:0] FMT_RESET      = FMT_RGBA8_UNORM;

    // per-channel conversion modes
    typedef enum logic [2:0] {
        MODE_ZERO  = 3'd0,
        MODE_U8N   = 3'd1,
        MODE_U8I   = 3'd2,
        MODE_U16N  = 3'd3,
        MODE_U16I  = 3'd4,
        MODE_PASS  = 3'd5
    } mode_t;

    typedef struct packed {
        logic             u16;    // 65535 range, else 255
        logic             scale;  // multiply before clamp
        logic             pass;
        logic             zero;
    } ctl_t;

    function automatic ctl_t mode_ctl(input mode_t m);
        ctl_t c;
        c = '{u16: 1'b0, scale: 1'b0, pass: 1'b0, zero: 1'b0};
        unique case (m)
            MODE_ZERO: c.zero = 1'b1;
            MODE_U8N:  c.scale = 1'b1;
            MODE_U8I:  ;
            MODE_U16N: begin c.u16 = 1'b1; c.scale = 1'b1; end
            MODE_U16I: c.u16 = 1'b1;
            MODE_PASS: c.pass = 1'b1;
            default:   c.zero = 1'b1;
        endcase
        return c;
    endfunction
endpackage
`default_nettype wire

### rtl/core/float4_to_texel_pack.sv
// Top level: four-channel float32 to texel format packer.
//  channel | signals                         | request
//  s_      | s_tvalid s_tready s_tdata[127:0] | one color
//  m_      | m_tvalid m_tready m_tdata[135:0] | packed channels
//  cfg     | cfg_valid cfg_ready cfg_data[3:0]| format code
// One color per cycle while m_tready does not stall the pipeline; results pass through the four lane stages.
// Reset clears valid bits and sets the format to rgba8 unorm.
// A stall on m_tready freezes all stages; s_tready falls only when the last stage is full and held.
`default_nettype none
module float4_to_texel_pack (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [127:0]           s_tdata,  // red_in, green_in, blue_in, alpha_in
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [135:0]                m_tdata,  // x, y, z, w, channels_used, 5'b0
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [f4tp_pkg::FmtW-1:0] cfg_data
);
    import f4tp_pkg::*;

    logic [FmtW-1:0] fmt_reg;
    logic [3:0]      vld_reg;
    logic [UsedW-1:0] used_reg [4];
    logic            en;
    mode_t           mode [4];
    logic [UsedW-1:0] used_next;
    logic [31:0]     lane_out [4];

    assign en        = !vld_reg[3] || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_RESET;
            vld_reg <= '0;
        end else begin
            if (cfg_valid) fmt_reg <= cfg_data;
            if (en) vld_reg <= {vld_reg[2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            used_reg[0] <= used_next;
            used_reg[1] <= used_reg[0];
            used_reg[2] <= used_reg[1];
            used_reg[3] <= used_reg[2];
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) mode[i] = MODE_ZERO;
        used_next = 3'd4;
        unique case (fmt_reg)
            FMT_R8_UNORM: begin mode[0] = MODE_U8N; used_next = 3'd1; end
            FMT_R8_UINT:  begin mode[0] = MODE_U8I; used_next = 3'd1; end
            FMT_RG8_UNORM: begin
                mode[0] = MODE_U8N; mode[1] = MODE_U8N; used_next = 3'd2;
            end
            FMT_RGB8_UNORM: begin
                mode[0] = MODE_U8N; mode[1] = MODE_U8N; mode[2] = MODE_U8N;
                used_next = 3'd3;
            end
            FMT_RGBA8_UNORM: begin
                for (int i = 0; i < 4; i++) mode[i] = MODE_U8N;
            end
            FMT_R16_UNORM: begin mode[0] = MODE_U16N; used_next = 3'd1; end
            FMT_R16_UINT:  begin mode[0] = MODE_U16I; used_next = 3'd1; end
            FMT_F32_X1: begin mode[0] = MODE_PASS; used_next = 3'd1; end
            FMT_F32_X2: begin
                mode[0] = MODE_PASS; mode[1] = MODE_PASS; used_next = 3'd2;
            end
            FMT_F32_X3: begin
                mode[0] = MODE_PASS; mode[1] = MODE_PASS; mode[2] = MODE_PASS;
                used_next = 3'd3;
            end
            FMT_F32_X4: begin
                for (int i = 0; i < 4; i++) mode[i] = MODE_PASS;
            end
            default: used_next = 3'd4;
        endcase
    end

    for (genvar k = 0; k < 4; k++) begin : g_lane
        f4tp_lane u_lane (
            .aclk (aclk),
            .en   (en),
            .ctl  (mode_ctl(mode[k])),
            .din  (s_tdata[32*k +: 32]),
            .dout (lane_out[k])
        );
    end

    assign m_tdata = {5'd0, used_reg[3], lane_out[3], lane_out[2], lane_out[1], lane_out[0]};

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_used_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[130:128] != 3'd0 && m_tdata[130:128] <= 3'd4))
        else $error("channels_used out of range");
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready ##1 s_tready ##1 s_tready ##1 s_tready |=> m_tvalid)
        else $error("request lost in pipeline");
`endif
endmodule
`default_nettype wire

### rtl/core/f4tp_lane.sv
// Pipelined float32 to clamped integer conversion for one channel (four stages).
`default_nettype none
module f4tp_lane (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire f4tp_pkg::ctl_t       ctl,
    input  wire logic [31:0]          din,
    output logic [31:0]               dout
);
    import f4tp_pkg::*;

    // stage 1: unpack, multiply mantissa by 255 or 65535 when scaling (exact product)
    logic [31:0] s1_bits_reg;
    ctl_t        s1_ctl_reg;
    logic        s1_sign_reg, s1_nan_reg, s1_inf_reg, s1_zero_reg;
    logic [7:0]  s1_exp_reg;
    logic [40:0] s1_prod_reg;

    logic [23:0] mant;
    logic [40:0] prod_next;
    logic [7:0]  e;
    always_comb begin
        e = din[30:23];
        mant = {(e != 8'd0), din[22:0]};
        if (!ctl.scale)
            prod_next = {17'd0, mant};
        else if (ctl.u16)
            prod_next = {1'b0, mant, 16'd0} - {17'd0, mant};
        else
            prod_next = {9'd0, mant, 8'd0} - {17'd0, mant};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_bits_reg <= din;
            s1_ctl_reg  <= ctl;
            s1_sign_reg <= din[31];
            s1_nan_reg  <= (e == 8'hFF) && (din[22:0] != 23'd0);
            s1_inf_reg  <= (e == 8'hFF) && (din[22:0] == 23'd0);
            s1_zero_reg <= (e == 8'd0);
            s1_exp_reg  <= e;
            s1_prod_reg <= prod_next;
        end
    end

    // stage 2: normalize product to 24 bits with round-to-nearest-even
    logic [31:0] s2_bits_reg;
    ctl_t        s2_ctl_reg;
    logic        s2_neg_reg, s2_big_reg;
    logic [9:0]  s2_exp_reg;
    logic [23:0] s2_mant_reg;

    logic [5:0]  msb;
    logic [40:0] sh;
    logic [16:0] drop_mask;
    logic [24:0] rnd;
    logic [23:0] nm;
    logic [9:0]  ne;
    logic        g, st, lsb;
    logic [4:0]  shamt;
    always_comb begin
        // the product's leading one sits at bit 23, 30/31, or 38/39
        msb = 6'd23;
        if (s1_ctl_reg.scale) begin
            if (s1_ctl_reg.u16)
                msb = s1_prod_reg[39] ? 6'd39 : 6'd38;
            else
                msb = s1_prod_reg[31] ? 6'd31 : 6'd30;
        end
        shamt = 5'(msb - 6'd23);
        sh = s1_prod_reg >> shamt;
        drop_mask = 17'((18'd1 << shamt) - 18'd1);
        g   = (shamt != 5'd0) && s1_prod_reg[shamt - 5'd1];
        st  = (({24'd0, s1_prod_reg[16:0]} & {24'd0, drop_mask >> 1}) != 41'd0);
        lsb = sh[0];
        rnd = {1'b0, sh[23:0]} + {24'd0, g & (st | lsb)};
        if (rnd[24]) begin
            nm = rnd[24:1];
            ne = {2'd0, s1_exp_reg} + {5'd0, shamt} + 10'd1;
        end else begin
            nm = rnd[23:0];
            ne = {2'd0, s1_exp_reg} + {5'd0, shamt};
        end
        if (s1_zero_reg) ne = 10'd1;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_bits_reg <= s1_bits_reg;
            s2_ctl_reg  <= s1_ctl_reg;
            s2_neg_reg  <= s1_nan_reg || s1_sign_reg;
            s2_big_reg  <= s1_inf_reg;
            s2_exp_reg  <= ne;
            s2_mant_reg <= nm;
        end
    end

    // stage 3: truncate toward zero and flag out-of-range values (value = mant * 2^(exp-150))
    logic [31:0] s3_bits_reg;
    ctl_t        s3_ctl_reg;
    logic        s3_neg_reg, s3_sat_reg;
    logic [16:0] s3_int_reg;

    logic [16:0] ival;
    logic        sat;
    logic [9:0]  rs;
    always_comb begin
        ival = 17'd0;
        sat  = s2_big_reg;
        rs   = 10'd150 - s2_exp_reg;
        if (s2_exp_reg >= 10'd151) sat = 1'b1;
        else if (rs < 10'd24) ival = 17'(s2_mant_reg >> rs[4:0]);
        if (s2_ctl_reg.u16) begin
            if (s2_exp_reg >= 10'd143) sat = 1'b1;
        end else begin
            if (s2_exp_reg >= 10'd135) sat = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_bits_reg <= s2_bits_reg;
            s3_ctl_reg  <= s2_ctl_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_sat_reg  <= sat;
            s3_int_reg  <= ival;
        end
    end

    // stage 4: clamp and select
    logic [16:0] maxv;
    logic [31:0] res_next, res_reg;
    always_comb begin
        maxv = s3_ctl_reg.u16 ? 17'd65535 : 17'd255;
        if (s3_ctl_reg.zero || s3_neg_reg && !s3_ctl_reg.pass)
            res_next = 32'd0;
        else if (s3_ctl_reg.pass)
            res_next = s3_bits_reg;
        else if (s3_sat_reg || s3_int_reg >= maxv)
            res_next = {15'd0, maxv};
        else
            res_next = {15'd0, s3_int_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) res_reg <= res_next;
    end

    assign dout = res_reg;
endmodule
`default_nettype wire
